>>> rtl/pld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pld_pkg;

  localparam int COEFF_FRAC_BITS_DEF = 28;
  localparam int CFG_IDX_W = 4;
  localparam int DIV_NUM_W = 48;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL  = 4'd0,
    REG_CENTER = 4'd1,
    REG_SKEW   = 4'd2,
    REG_K1     = 4'd3,
    REG_K2     = 4'd4,
    REG_K3     = 4'd5,
    REG_P1     = 4'd6,
    REG_P2     = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        fx;
    logic [31:0]        fy;
    logic [31:0]        cx;
    logic [31:0]        cy;
    logic signed [31:0] skew;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } pld_coef_t;

  // round half up, then floor shift
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p,
                                                   input int unsigned f);
    logic signed [63:0] t;
    t = p + (64'sd1 <<< (f - 1));
    return t >>> f;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = S32_MAX;
    else if (v < -64'sd2147483648) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pld_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: quot = sat32(trunc(num * 2^F / den)).
// One quotient bit per stage.
module pld_div #(
  parameter int F      = 28,
  parameter int NUM_W  = 48,
  parameter int SIDE_W = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      en,
  input  wire                      in_valid,
  input  wire signed [NUM_W-1:0]   num,
  input  wire        [31:0]        den,
  input  wire        [SIDE_W-1:0]  side,
  output logic                     out_valid,
  output logic signed [31:0]       quot,
  output logic       [SIDE_W-1:0]  side_out
);
  import pld_pkg::*;

  localparam int QB = 33;
  localparam int SH = QB - F;

  logic [QB:0]        vld;
  logic [31:0]        rem   [QB+1];
  logic [QB-1:0]      qacc  [QB+1];
  logic [NUM_W-1:0]   mag_s [QB+1];
  logic [31:0]        den_s [QB+1];
  logic               neg_s [QB+1];
  logic               ovf_s [QB+1];
  logic [SIDE_W-1:0]  side_s[QB+1];

  logic [NUM_W-1:0] mag_in;
  logic [NUM_W-1:0] hi_in;
  logic             ovf_in;

  always_comb begin
    mag_in = num[NUM_W-1] ? (~num + 1'b1) : num;
    hi_in  = mag_in >> SH;
    // quotient would not fit in 33 bits; zero over zero stays zero
    ovf_in = (hi_in >= {{(NUM_W-32){1'b0}}, den}) && (mag_in != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      rem[0]    <= hi_in[31:0];
      qacc[0]   <= '0;
      mag_s[0]  <= mag_in;
      den_s[0]  <= den;
      neg_s[0]  <= num[NUM_W-1];
      ovf_s[0]  <= ovf_in;
      side_s[0] <= side;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int I = QB - 1 - k;
    logic        bin;
    logic [32:0] r2;
    logic [32:0] rd;
    logic        ge;

    if (I >= F) begin : g_bit
      assign bin = mag_s[k][I-F];
    end else begin : g_zero
      assign bin = 1'b0;
    end

    assign r2 = {rem[k], bin};
    assign rd = r2 - {1'b0, den_s[k]};
    // a zero divisor never subtracts, so zero over zero gives zero
    assign ge = (r2 >= {1'b0, den_s[k]}) && (den_s[k] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]    <= ge ? rd[31:0] : r2[31:0];
        qacc[k+1]   <= {qacc[k][QB-2:0], ge};
        mag_s[k+1]  <= mag_s[k];
        den_s[k+1]  <= den_s[k];
        neg_s[k+1]  <= neg_s[k];
        ovf_s[k+1]  <= ovf_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  logic [QB-1:0] qf;
  assign qf = qacc[QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QB];
    end
    if (en) begin
      side_out <= side_s[QB];
      if (neg_s[QB]) begin
        if (ovf_s[QB] || qf > 33'h080000000) quot <= S32_MIN;
        else quot <= ~qf[31:0] + 32'd1;
      end else begin
        if (ovf_s[QB] || qf > 33'h07fffffff) quot <= S32_MAX;
        else quot <= qf[31:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/pld_dist.sv
`timescale 1ns / 1ps
`default_nettype none

// Distortion polynomial and back projection, 13 stages.
module pld_dist #(
  parameter int F = 28
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     en,
  input  wire                     in_valid,
  input  wire signed [31:0]       x,
  input  wire signed [31:0]       y,
  input  pld_pkg::pld_coef_t      coef,
  output logic                    out_valid,
  output logic signed [31:0]      dist_x,
  output logic signed [31:0]      dist_y,
  output logic                    saturated
);
  import pld_pkg::*;

  localparam logic signed [63:0] ONE = 64'sd1 <<< F;

  logic [11:0] vld;

  logic signed [31:0] a_x, a_y;
  logic signed [63:0] a_xx, a_yy, a_xy;
  logic signed [31:0] b_x, b_y, b_x2, b_y2, b_xy;
  logic signed [31:0] c_x, c_y, c_x2, c_y2, c_xy, c_r2;
  logic signed [31:0] d_x, d_y, d_xy, d_r2, d_a, d_b;
  logic signed [63:0] d_r2r2, d_k1r2;
  logic signed [31:0] e_x, e_y, e_xy, e_r2, e_a, e_b, e_r4;
  logic signed [63:0] e_k1r2;
  logic signed [31:0] f_x, f_y;
  logic signed [63:0] f_k1r2, f_r6p, f_k2r4p, f_p1xyp, f_p2xyp, f_p2ap, f_p1bp;
  logic signed [31:0] g_x, g_y, g_r6;
  logic signed [63:0] g_k1r2, g_k2r4, g_p1xy, g_p2xy, g_p2a, g_p1b;
  logic signed [31:0] h_x, h_y;
  logic signed [63:0] h_ksum, h_k3r6p, h_tx, h_ty;
  logic signed [31:0] i_x, i_y, i_rr;
  logic signed [63:0] i_tx, i_ty;
  logic signed [63:0] j_xrr, j_yrr, j_tx, j_ty;
  logic signed [31:0] k_xd, k_yd;
  logic signed [63:0] l_fxp, l_skp, l_fyp;
  logic signed [63:0] ox_sum, oy_sum;

  always_comb begin
    ox_sum = rnd_shift(l_fxp, F) + rnd_shift(l_skp, F) + $signed({32'd0, coef.cx});
    oy_sum = rnd_shift(l_fyp, F) + $signed({32'd0, coef.cy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[10:0], in_valid};
      out_valid <= vld[11];
    end
    if (en) begin
      // squares and cross term
      a_x <= x; a_y <= y;
      a_xx <= x * x; a_yy <= y * y; a_xy <= x * y;
      b_x <= a_x; b_y <= a_y;
      b_x2 <= sat32(rnd_shift(a_xx, F));
      b_y2 <= sat32(rnd_shift(a_yy, F));
      b_xy <= sat32(rnd_shift(a_xy, F));
      c_x <= b_x; c_y <= b_y; c_x2 <= b_x2; c_y2 <= b_y2; c_xy <= b_xy;
      c_r2 <= sat32(64'(b_x2) + 64'(b_y2));
      // r^4 and k1 r^2 products, tangential sums
      d_x <= c_x; d_y <= c_y; d_xy <= c_xy; d_r2 <= c_r2;
      d_r2r2 <= c_r2 * c_r2;
      d_k1r2 <= coef.k1 * c_r2;
      d_a <= sat32(64'(c_r2) + 2 * 64'(c_x2));
      d_b <= sat32(64'(c_r2) + 2 * 64'(c_y2));
      e_x <= d_x; e_y <= d_y; e_xy <= d_xy; e_r2 <= d_r2; e_a <= d_a; e_b <= d_b;
      e_r4 <= sat32(rnd_shift(d_r2r2, F));
      e_k1r2 <= rnd_shift(d_k1r2, F);
      f_x <= e_x; f_y <= e_y; f_k1r2 <= e_k1r2;
      f_r6p <= e_r4 * e_r2;
      f_k2r4p <= coef.k2 * e_r4;
      f_p1xyp <= coef.p1 * e_xy;
      f_p2xyp <= coef.p2 * e_xy;
      f_p2ap <= coef.p2 * e_a;
      f_p1bp <= coef.p1 * e_b;
      g_x <= f_x; g_y <= f_y; g_k1r2 <= f_k1r2;
      g_r6 <= sat32(rnd_shift(f_r6p, F));
      g_k2r4 <= rnd_shift(f_k2r4p, F);
      g_p1xy <= rnd_shift(f_p1xyp, F);
      g_p2xy <= rnd_shift(f_p2xyp, F);
      g_p2a <= rnd_shift(f_p2ap, F);
      g_p1b <= rnd_shift(f_p1bp, F);
      h_x <= g_x; h_y <= g_y;
      h_ksum <= ONE + g_k1r2 + g_k2r4;
      h_k3r6p <= coef.k3 * g_r6;
      h_tx <= 2 * g_p1xy + g_p2a;
      h_ty <= g_p1b + 2 * g_p2xy;
      i_x <= h_x; i_y <= h_y; i_tx <= h_tx; i_ty <= h_ty;
      i_rr <= sat32(h_ksum + rnd_shift(h_k3r6p, F));
      j_xrr <= i_x * i_rr; j_yrr <= i_y * i_rr;
      j_tx <= i_tx; j_ty <= i_ty;
      k_xd <= sat32(rnd_shift(j_xrr, F) + j_tx);
      k_yd <= sat32(rnd_shift(j_yrr, F) + j_ty);
      // back to pixels
      l_fxp <= $signed({1'b0, coef.fx}) * k_xd;
      l_skp <= coef.skew * k_yd;
      l_fyp <= $signed({1'b0, coef.fy}) * k_yd;
      dist_x <= sat32(ox_sum);
      dist_y <= sat32(oy_sum);
      saturated <= (ox_sum != 64'(sat32(ox_sum))) || (oy_sum != 64'(sat32(oy_sum)));
    end
  end

endmodule

`default_nettype wire

>>> rtl/pixel_lens_distortion.sv
`timescale 1ns / 1ps
`default_nettype none
// Path from input transaction to result: y divider, 2 skew stages, x divider,
// 13 polynomial stages.
// Throughput: one point per cycle while the output is not stalled; the two 33-step divider pipelines set the depth.
// A stall on the output freezes every stage together.
// Reset (rst, synchronous): clears all valid bits, loads fx = fy = 0x0001_0000, other regs 0.
module pixel_lens_distortion #(
  parameter int COEFF_FRAC_BITS = pld_pkg::COEFF_FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire  [63:0]                      s_tdata,   // pixel_x, pixel_y
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [63:0]                      m_tdata,   // dist_x, dist_y
  output logic [0:0]                       m_tuser,   // saturated
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [pld_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [63:0]                      cfg_data
);
  import pld_pkg::*;

  localparam int NW = DIV_NUM_W;

  pld_coef_t coef;
  logic      en;

  assign cfg_ready = 1'b1;
  assign en        = m_tready || !m_tvalid;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.fx   <= 32'h0001_0000;
      coef.fy   <= 32'h0001_0000;
      coef.cx   <= '0;
      coef.cy   <= '0;
      coef.skew <= '0;
      coef.k1   <= '0;
      coef.k2   <= '0;
      coef.k3   <= '0;
      coef.p1   <= '0;
      coef.p2   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FOCAL:  begin
          coef.fx <= cfg_data[31:0];
          coef.fy <= cfg_data[63:32];
        end
        REG_CENTER: begin
          coef.cx <= cfg_data[31:0];
          coef.cy <= cfg_data[63:32];
        end
        REG_SKEW:   coef.skew <= cfg_data[31:0];
        REG_K1:     coef.k1   <= cfg_data[31:0];
        REG_K2:     coef.k2   <= cfg_data[31:0];
        REG_K3:     coef.k3   <= cfg_data[31:0];
        REG_P1:     coef.p1   <= cfg_data[31:0];
        REG_P2:     coef.p2   <= cfg_data[31:0];
        default:    ;
      endcase
    end
  end

  // y normalization
  logic signed [31:0]   px, py;
  logic signed [NW-1:0] ny_num;
  assign px     = s_tdata[31:0];
  assign py     = s_tdata[63:32];
  assign ny_num = $signed({{(NW-32){py[31]}}, py}) - $signed({{(NW-32){1'b0}}, coef.cy});

  logic               dy_valid;
  logic signed [31:0] dy_quot;
  logic [31:0]        dy_px;

  pld_div #(.F(COEFF_FRAC_BITS), .NUM_W(NW), .SIDE_W(32)) u_div_y (
    .clk, .rst, .en,
    .in_valid (s_tvalid && s_tready),
    .num      (ny_num),
    .den      (coef.fy),
    .side     (px),
    .out_valid(dy_valid),
    .quot     (dy_quot),
    .side_out (dy_px)
  );

  // skew removal: x numerator = px - cx - round(skew * y)
  logic               g1_valid, g2_valid;
  logic signed [31:0] g1_y, g1_px, g2_y;
  logic signed [63:0] g1_prod, g2_full;
  logic signed [NW-1:0] g2_nx;

  assign g2_full = 64'(g1_px) - $signed({32'd0, coef.cx})
                 - rnd_shift(g1_prod, COEFF_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_valid <= 1'b0;
      g2_valid <= 1'b0;
    end else if (en) begin
      g1_valid <= dy_valid;
      g2_valid <= g1_valid;
    end
    if (en) begin
      g1_y    <= dy_quot;
      g1_px   <= dy_px;
      g1_prod <= coef.skew * dy_quot;
      g2_y    <= g1_y;
      g2_nx   <= g2_full[NW-1:0];
    end
  end

  logic               dx_valid;
  logic signed [31:0] dx_quot;
  logic [31:0]        dx_y;

  pld_div #(.F(COEFF_FRAC_BITS), .NUM_W(NW), .SIDE_W(32)) u_div_x (
    .clk, .rst, .en,
    .in_valid (g2_valid),
    .num      (g2_nx),
    .den      (coef.fx),
    .side     (g2_y),
    .out_valid(dx_valid),
    .quot     (dx_quot),
    .side_out (dx_y)
  );

  logic               o_valid, o_sat;
  logic signed [31:0] o_x, o_y;

  pld_dist #(.F(COEFF_FRAC_BITS)) u_dist (
    .clk, .rst, .en,
    .in_valid (dx_valid),
    .x        (dx_quot),
    .y        ($signed(dx_y)),
    .coef     (coef),
    .out_valid(o_valid),
    .dist_x   (o_x),
    .dist_y   (o_y),
    .saturated(o_sat)
  );

  assign m_tvalid   = o_valid;
  assign m_tdata    = {o_y, o_x};
  assign m_tuser[0] = o_sat;

  // a clipped result must sit on a limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
       m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000))
    else $error("saturated flag without a clipped coordinate");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
